// ----- rtl/bawr_pkg.sv -----
// Shared types and constants for the block allocator with reuse table.
// No dependencies; imported by the allocator core and by bawr_checker.
package bawr_pkg;

  localparam int unsigned SizeW = 18;
  localparam int unsigned OffsW = 17;

  // Opcode and status codes
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_FREE   = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FAIL   = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [SizeW-1:0] request_size;
    logic [OffsW-1:0] block_offset;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [OffsW-1:0] granted_offset;
  } rsp_t;

  // One block record as held in the record table
  typedef struct packed {
    logic [OffsW-1:0] start;
    logic [SizeW-1:0] length;
    logic             is_free;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

endpackage

// ----- rtl/bawr_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bawr_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, or read into the registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bump_allocator_with_reuse_table_core.sv -----
// Top level of the block allocator: bump pointer, record table scan, result register.
// Depends on bawr_pkg and bawr_ram.
//
// Usage:
//   Command channel: a beat on req_i is taken at a rising edge with start high
//   and busy low. Each command yields exactly one result beat on rsp_o, marked
//   by done_o for a single cycle; the receiver cannot stall it.
//   Allocate while table slots remain: the block is carved from the bump pointer
//   (or fails when the heap is exhausted); done_o rises the cycle after the
//   command, busy stays low, so such commands can issue every cycle.
//   Allocate with a full table, and every deallocate: the record table is
//   scanned in order, one record per cycle from the single-port table RAM
//   (registered read data, reads overlapped with checks); busy stays high
//   until the last record has been checked or a hit is found.
//   A hit writes the record back in the same port and ends the scan at once.
//   Reset empties the table (record count and bump pointer to zero); no
//   clearing pass is needed, records are only read after being written.
module bump_allocator_with_reuse_table_core
  import bawr_pkg::*;
#(
  parameter int unsigned HEAP_BYTES = 131072,
  parameter int unsigned SLOTS      = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW  = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned BumpW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SumW  = ((BumpW > SizeW) ? BumpW : SizeW) + 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e           state_q, state_d;
  logic [BumpW-1:0] bump_q, bump_d;
  logic [CntW-1:0]  used_q, used_d;
  req_t             cmd_q, cmd_d;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]  chk_idx_q, chk_idx_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic             table_full;
  logic [SumW-1:0]  bump_ext;
  logic [SumW-1:0]  bump_end;
  logic             bump_fits;
  logic             hit;
  rec_t             rec_rd;
  rec_t             rec_wr;
  logic             ram_we;
  logic [IdxW-1:0]  ram_addr;
  logic [RecW-1:0]  ram_rdata;

  assign accept     = start && !busy;
  assign table_full = (used_q == CntW'(SLOTS));

  // Bump path arithmetic
  assign bump_ext  = SumW'(bump_q);
  assign bump_end  = bump_ext + SumW'(req_i.request_size);
  assign bump_fits = (bump_end <= SumW'(HEAP_BYTES));

  // Record check on the data read last cycle
  assign rec_rd = rec_t'(ram_rdata);
  always_comb begin
    if (cmd_q.opcode == OP_ALLOC) begin
      hit = chk_vld_q && rec_rd.is_free && (rec_rd.length >= cmd_q.request_size);
    end else begin
      hit = chk_vld_q && !rec_rd.is_free && (rec_rd.start == cmd_q.block_offset);
    end
  end

  // Next state, table port and result
  always_comb begin
    state_d   = state_q;
    bump_d    = bump_q;
    used_d    = used_q;
    cmd_d     = cmd_q;
    limit_d   = limit_q;
    rd_cnt_d  = rd_cnt_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_addr  = rd_cnt_q[IdxW-1:0];
    rec_wr    = rec_rd;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = req_i;
          rd_cnt_d = '0;
          if (req_i.opcode == OP_ALLOC && !table_full) begin
            // Carve a new block from the bump pointer
            done_d               = 1'b1;
            rsp_d.status         = ST_FAIL;
            rsp_d.granted_offset = '0;
            if (bump_fits) begin
              ram_we               = 1'b1;
              ram_addr             = used_q[IdxW-1:0];
              rec_wr.start         = bump_ext[OffsW-1:0];
              rec_wr.length        = req_i.request_size;
              rec_wr.is_free       = 1'b0;
              used_d               = used_q + 1'b1;
              bump_d               = bump_end[BumpW-1:0];
              rsp_d.status         = ST_OK;
              rsp_d.granted_offset = bump_ext[OffsW-1:0];
            end
          end else begin
            // Reuse search covers all slots; release search the written ones
            state_d = S_SCAN;
            limit_d = (req_i.opcode == OP_ALLOC) ? CntW'(SLOTS) : used_q;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we               = 1'b1;
          ram_addr             = chk_idx_q;
          rec_wr.is_free       = (cmd_q.opcode == OP_FREE);
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.status         = ST_OK;
          rsp_d.granted_offset = (cmd_q.opcode == OP_ALLOC) ? rec_rd.start : '0;
        end else if (rd_cnt_q == limit_q) begin
          // Nothing left in flight: no match
          state_d              = S_IDLE;
          done_d               = 1'b1;
          rsp_d.status         = ST_FAIL;
          rsp_d.granted_offset = '0;
        end else begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_cnt_q[IdxW-1:0];
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bump_q    <= '0;
      used_q    <= '0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bump_q    <= bump_d;
      used_q    <= used_d;
      chk_vld_q <= chk_vld_d;
      done_q    <= done_d;
    end
  end

  // Command and scan payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    limit_q   <= limit_d;
    rd_cnt_q  <= rd_cnt_d;
    chk_idx_q <= chk_idx_d;
    rsp_q     <= rsp_d;
  end

  // Record table
  bawr_ram #(
    .Width (RecW),
    .Depth (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (rec_wr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/bawr_checker.sv -----
// Port-level checks for the block allocator core, with the bind that attaches them.
// Depends on bawr_pkg and bump_allocator_with_reuse_table_core.
module bawr_checker
  import bawr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted beat either starts a scan or answers next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither busy nor answered");

  // No result while a scan is still running
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe during scan");

  // End of a scan always delivers its result
  a_scan_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("scan ended without a result");

  // Failures carry a zero offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FAIL) |-> (rsp_o.granted_offset == '0))
    else $error("failed result with nonzero offset");

endmodule

bind bump_allocator_with_reuse_table_core bawr_checker u_bawr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
